@@ rtl/cfw_pkg.sv @@
// Package for the chunked body framer: job descriptor, codes and queue sizing.
// No dependencies; used by every module under rtl.
package cfw_pkg;

  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_DATA   = 3'd1,
    ACT_END    = 3'd2,
    ACT_NAME   = 3'd3,
    ACT_VALUE  = 3'd4,
    ACT_FINISH = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SEQ = 2'd1,
    ST_LEN = 2'd2
  } status_e;

  // What the back end has to emit for one accepted request
  typedef enum logic [1:0] {
    JOB_HEX  = 2'd0,  // length digits, CR, LF
    JOB_BYTE = 2'd1,  // optional colon, byte, optional CR LF
    JOB_CRLF = 2'd2,  // CR, LF
    JOB_ERR  = 2'd3   // single zero byte carrying a status
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  data;
    logic        colon;
    logic        crlf;
    logic [16:0] length;
    logic [2:0]  ndig;
    status_e     status;
    logic [39:0] count;
  } job_t;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCntW   = 3;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;

  localparam logic [16:0] LimitReset = 17'h10000;
  localparam logic [39:0] CountMax   = 40'hff_ffff_ffff;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

@@ rtl/cfw_front.sv @@
// Front end: accepts requests, tracks framing order and sticky error, and
// turns each request into one job descriptor. Depends on cfw_pkg.
module cfw_front
  import cfw_pkg::*;
#(
  parameter int unsigned MAX_CHUNK = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [16:0] chunk_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        line_last_i,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output job_t        q_job_o
);

  typedef enum logic [2:0] {
    PH_AWAIT      = 3'd0,
    PH_DATA       = 3'd1,
    PH_LINE_START = 3'd2,
    PH_LINE       = 3'd3,
    PH_DONE       = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [16:0] bytes_left_q, bytes_left_d;
  logic        in_value_q, in_value_d;
  logic        error_q, error_d;
  logic [39:0] count_q, count_d;
  logic [16:0] limit_q;

  logic        accept;
  logic        len_bad;
  logic [2:0]  ndig;
  logic [16:0] left_dec;
  job_t        job;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_job_o    = job;

  assign len_bad = (chunk_length_i == 17'd0)
                || ({15'd0, chunk_length_i} > {15'd0, limit_q})
                || ({15'd0, chunk_length_i} > 32'(MAX_CHUNK));
  assign left_dec = bytes_left_q - 17'd1;

  always_comb begin
    if (chunk_length_i[16]) begin
      ndig = 3'd5;
    end else if (chunk_length_i[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (chunk_length_i[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (chunk_length_i[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    in_value_d   = in_value_q;
    error_d      = error_q;
    count_d      = count_q;

    job        = '0;
    job.kind   = JOB_ERR;
    job.status = ST_SEQ;
    job.length = chunk_length_i;
    job.ndig   = ndig;
    job.data   = data_byte_i;

    if (!error_q) begin
      case (action_i)
        ACT_START: begin
          if (phase_q != PH_AWAIT) begin
            error_d = 1'b1;
          end else if (len_bad) begin
            error_d    = 1'b1;
            job.status = ST_LEN;
          end else begin
            job.kind     = JOB_HEX;
            job.status   = ST_OK;
            bytes_left_d = chunk_length_i;
            phase_d      = PH_DATA;
          end
        end
        ACT_DATA: begin
          if (phase_q != PH_DATA) begin
            error_d = 1'b1;
          end else begin
            job.kind     = JOB_BYTE;
            job.status   = ST_OK;
            job.crlf     = (left_dec == 17'd0);
            bytes_left_d = left_dec;
            if (count_q != CountMax) begin
              count_d = count_q + 40'd1;
            end
            if (left_dec == 17'd0) begin
              phase_d = PH_AWAIT;
            end
          end
        end
        ACT_END: begin
          if (phase_q != PH_AWAIT) begin
            error_d = 1'b1;
          end else begin
            job.kind   = JOB_BYTE;
            job.status = ST_OK;
            job.data   = ChZero;
            job.crlf   = 1'b1;
            phase_d    = PH_LINE_START;
            in_value_d = 1'b0;
          end
        end
        ACT_NAME: begin
          if (!(phase_q == PH_LINE_START || (phase_q == PH_LINE && !in_value_q))) begin
            error_d = 1'b1;
          end else begin
            job.kind   = JOB_BYTE;
            job.status = ST_OK;
            phase_d    = PH_LINE;
          end
        end
        ACT_VALUE: begin
          if (phase_q != PH_LINE) begin
            error_d = 1'b1;
          end else begin
            job.kind   = JOB_BYTE;
            job.status = ST_OK;
            job.colon  = !in_value_q;
            job.crlf   = line_last_i;
            in_value_d = 1'b1;
            if (line_last_i) begin
              in_value_d = 1'b0;
              phase_d    = PH_LINE_START;
            end
          end
        end
        ACT_FINISH: begin
          if (phase_q != PH_LINE_START) begin
            error_d = 1'b1;
          end else begin
            job.kind   = JOB_CRLF;
            job.status = ST_OK;
            phase_d    = PH_DONE;
          end
        end
        default: begin
          error_d = 1'b1;
        end
      endcase
    end

    job.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_AWAIT;
      bytes_left_q <= '0;
      in_value_q   <= 1'b0;
      error_q      <= 1'b0;
      count_q      <= '0;
      limit_q      <= LimitReset;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q      <= phase_d;
        bytes_left_q <= bytes_left_d;
        in_value_q   <= in_value_d;
        error_q      <= error_d;
        count_q      <= count_d;
      end
    end
  end

endmodule

@@ rtl/cfw_queue.sv @@
// Short job queue between the front and back ends of the framer.
// Register array with head and tail pointers. Depends on cfw_pkg.
module cfw_queue
  import cfw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

@@ rtl/cfw_back.sv @@
// Back end: expands each queued job into framed bytes, one per cycle unless the
// output stalls, into an output register. Depends on cfw_pkg.
module cfw_back
  import cfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  job_t        q_job_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [39:0] bytes_sent_o
);

  logic        valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [1:0]  status_q;
  logic [39:0] count_q;
  logic [2:0]  step_q;

  logic        load;
  logic [2:0]  n_bytes;
  logic        at_end;
  logic [7:0]  byte_d;
  logic [2:0]  nib_idx;
  logic [3:0]  nibble;
  logic [2:0]  rel;

  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign at_end  = (step_q == n_bytes - 3'd1);
  assign q_pop_o = load && at_end;
  assign nib_idx = q_job_i.ndig - 3'd1 - step_q;
  assign rel     = step_q - {2'd0, q_job_i.colon};

  always_comb begin
    case (q_job_i.kind)
      JOB_HEX:  n_bytes = q_job_i.ndig + 3'd2;
      JOB_BYTE: n_bytes = 3'd1 + {2'd0, q_job_i.colon} + {1'b0, q_job_i.crlf, 1'b0};
      JOB_CRLF: n_bytes = 3'd2;
      default:  n_bytes = 3'd1;
    endcase
  end

  always_comb begin
    case (nib_idx)
      3'd0:    nibble = q_job_i.length[3:0];
      3'd1:    nibble = q_job_i.length[7:4];
      3'd2:    nibble = q_job_i.length[11:8];
      3'd3:    nibble = q_job_i.length[15:12];
      3'd4:    nibble = {3'd0, q_job_i.length[16]};
      default: nibble = 4'd0;
    endcase
  end

  always_comb begin
    case (q_job_i.kind)
      JOB_HEX: begin
        if (step_q < q_job_i.ndig) begin
          byte_d = hex_char(nibble);
        end else if (step_q == q_job_i.ndig) begin
          byte_d = ChCr;
        end else begin
          byte_d = ChLf;
        end
      end
      JOB_BYTE: begin
        if (q_job_i.colon && step_q == 3'd0) begin
          byte_d = ChColon;
        end else if (rel == 3'd0) begin
          byte_d = q_job_i.data;
        end else if (rel == 3'd1) begin
          byte_d = ChCr;
        end else begin
          byte_d = ChLf;
        end
      end
      JOB_CRLF: byte_d = (step_q == 3'd0) ? ChCr : ChLf;
      default:  byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= at_end ? 3'd0 : step_q + 3'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload held while stalled; loaded only alongside a new byte
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      last_q   <= at_end;
      status_q <= q_job_i.status;
      count_q  <= q_job_i.count;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;
  assign status_o     = status_q;
  assign bytes_sent_o = count_q;

endmodule

@@ rtl/http_chunked_body_framer_core.sv @@
// Top level of the HTTP chunked body framer: front end, job queue, back end.
// Depends on cfw_pkg, cfw_front, cfw_queue and cfw_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | action, chunk_length, data_byte, line_last
//  out     | out       | out_valid_o / out_stall_i| out_byte, last, status, bytes_sent
//  cfg     | in        | cfg_we_i                 | cfg_wdata_i (chunk_limit)
//
// The front end takes one request per cycle while the four-entry job queue has room.
// The back end emits one framed byte per cycle while the output is not stalled; a request
// yields 1 to 7 bytes (a payload byte 1, a payload byte closing a chunk 3, a chunk start up to 7).
// The first result byte passes through the job queue and then the output register.
// Reset is asynchronous, active low, and needs no clearing pass.
// An output stall holds the output register; the queue then fills and stalls the input.
module http_chunked_body_framer_core
  import cfw_pkg::*;
#(
  parameter int unsigned MAX_CHUNK = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [16:0] chunk_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        line_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  output logic [39:0] bytes_sent_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  cfw_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .chunk_length_i(chunk_length_i),
    .data_byte_i   (data_byte_i),
    .line_last_i   (line_last_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  cfw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (head_job),
    .pop_i  (q_pop)
  );

  cfw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (head_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .bytes_sent_o(bytes_sent_o)
  );

endmodule

@@ rtl/cfw_checker.sv @@
// Port-level checks for the chunked body framer, bound to its top level.
// Depends on cfw_pkg and http_chunked_body_framer_core.
module cfw_checker
  import cfw_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic [1:0]  status_o,
  input logic [39:0] bytes_sent_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_o) && $stable(status_o) && $stable(bytes_sent_o))
    else $error("stalled result changed");

  // Error results are a single zero byte
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && out_byte_o == 8'd0)
    else $error("error result not a lone zero byte");

  // Only the closing byte of a request may carry an error
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_OK)
    else $error("error status on a non-final byte");

  // Payload count never goes backwards between consecutive results
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o |-> bytes_sent_o >= $past(bytes_sent_o))
    else $error("bytes_sent decreased");

endmodule

bind http_chunked_body_framer_core cfw_checker u_cfw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .status_o    (status_o),
  .bytes_sent_o(bytes_sent_o)
);

@@ test/testbench.sv @@
// Self-checking testbench for http_chunked_body_framer_core: random and directed requests,
// a bit-accurate framing predictor, and a byte-by-byte scoreboard on the output stream.
// Depends on cfw_pkg and the framer RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfw_pkg::*;

  localparam int unsigned MaxChunk   = 65536;
  localparam int unsigned CycleLimit = 400_000;
  localparam logic [16:0] LimitTop   = 17'h1ffff;
  localparam logic [7:0]  ChLowerA   = 8'h61;
  localparam logic [2:0]  ACT_SPARE_A = 3'd6;
  localparam logic [2:0]  ACT_SPARE_B = 3'd7;

  typedef enum logic [2:0] {
    AWAIT_CHUNK,
    IN_CHUNK,
    LINE_START,
    IN_LINE,
    BODY_DONE
  } body_phase_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [16:0] length;
    logic [7:0]  data;
    logic        line_last;
  } request_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
    logic [39:0] count;
  } framed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = '0;
  logic [16:0] chunk_length_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        line_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic [39:0] bytes_sent_o;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;

  http_chunked_body_framer_core #(
    .MAX_CHUNK(MaxChunk)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .chunk_length_i(chunk_length_i),
    .data_byte_i   (data_byte_i),
    .line_last_i   (line_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .bytes_sent_o  (bytes_sent_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  request_t    request_q[$];
  framed_t     framed_stream_q[$];
  framed_t     burst_q[$];
  request_t    offered;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned byte_faults = 0;
  int unsigned cycle_count = 0;

  // Framer state as the predictor sees it
  logic [16:0] limit_reg = LimitReset;
  body_phase_e body_phase = AWAIT_CHUNK;
  logic [16:0] chunk_left = '0;
  logic        in_value = 1'b0;
  logic        err_seen = 1'b0;
  logic [39:0] sent_count = '0;

  function automatic void add_byte(logic [7:0] b);
    burst_q.push_back('{data: b, last: 1'b0, status: ST_OK, count: sent_count});
  endfunction

  // Work out the framed bytes one request produces and advance the state
  function automatic void frame_request(request_t r);
    status_e     fault;
    logic [16:0] eff_limit;
    logic        lead;
    logic [3:0]  nib;
    fault = ST_OK;
    burst_q.delete();
    if (err_seen) begin
      fault = ST_SEQ;
    end else begin
      case (r.action)
        ACT_START: begin
          eff_limit = (limit_reg > MaxChunk) ? 17'(MaxChunk) : limit_reg;
          if (body_phase != AWAIT_CHUNK) begin
            fault = ST_SEQ;
          end else if (r.length == '0 || r.length > eff_limit) begin
            fault = ST_LEN;
          end else begin
            lead = 1'b0;
            // lower-case hex, no leading zeros
            for (int sh = 16; sh >= 0; sh -= 4) begin
              nib = 4'(r.length >> sh);
              if (nib != 4'd0 || lead) begin
                lead = 1'b1;
                add_byte((nib < 4'd10) ? ChZero + 8'(nib) : ChLowerA + 8'(nib) - 8'd10);
              end
            end
            add_byte(ChCr);
            add_byte(ChLf);
            chunk_left = r.length;
            body_phase = IN_CHUNK;
          end
        end
        ACT_DATA: begin
          if (body_phase != IN_CHUNK) begin
            fault = ST_SEQ;
          end else begin
            if (sent_count != CountMax) sent_count++;
            add_byte(r.data);
            chunk_left = chunk_left - 17'd1;
            if (chunk_left == '0) begin
              add_byte(ChCr);
              add_byte(ChLf);
              body_phase = AWAIT_CHUNK;
            end
          end
        end
        ACT_END: begin
          if (body_phase != AWAIT_CHUNK) begin
            fault = ST_SEQ;
          end else begin
            add_byte(ChZero);
            add_byte(ChCr);
            add_byte(ChLf);
            body_phase = LINE_START;
            in_value = 1'b0;
          end
        end
        ACT_NAME: begin
          if (!(body_phase == LINE_START || (body_phase == IN_LINE && !in_value))) begin
            fault = ST_SEQ;
          end else begin
            add_byte(r.data);
            body_phase = IN_LINE;
          end
        end
        ACT_VALUE: begin
          if (body_phase != IN_LINE) begin
            fault = ST_SEQ;
          end else begin
            if (!in_value) begin
              add_byte(ChColon);
              in_value = 1'b1;
            end
            add_byte(r.data);
            if (r.line_last) begin
              add_byte(ChCr);
              add_byte(ChLf);
              in_value = 1'b0;
              body_phase = LINE_START;
            end
          end
        end
        ACT_FINISH: begin
          if (body_phase != LINE_START) begin
            fault = ST_SEQ;
          end else begin
            add_byte(ChCr);
            add_byte(ChLf);
            body_phase = BODY_DONE;
          end
        end
        default: fault = ST_SEQ;
      endcase
    end
    if (fault != ST_OK) begin
      err_seen = 1'b1;
      burst_q.delete();
      burst_q.push_back('{data: 8'h00, last: 1'b0, status: fault, count: sent_count});
    end
    burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i]) framed_stream_q.push_back(burst_q[i]);
  endfunction

  // Request driver: offer the next request once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) frame_request(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = request_q.pop_front();
          in_valid_i     <= 1'b1;
          action_i       <= offered.action;
          chunk_length_i <= offered.length;
          data_byte_i    <= offered.data;
          line_last_i    <= offered.line_last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long output hold, counted down here
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) rx_hold_left--;
  end

  // Output monitor and stall generator
  always @(posedge clk_i) begin
    framed_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (framed_stream_q.size() == 0) begin
          byte_faults++;
          if (byte_faults <= 10)
            $display("%0t: byte %02h arrived with nothing outstanding", $time, out_byte_o);
        end else begin
          want = framed_stream_q.pop_front();
          if (out_byte_o !== want.data || last_o !== want.last ||
              status_o !== want.status || bytes_sent_o !== want.count) begin
            byte_faults++;
            if (byte_faults <= 10)
              $display({"%0t: mismatch: expected byte %02h last %0b status %0d count %0d,",
                        " got byte %02h last %0b status %0d count %0d"},
                       $time, want.data, want.last, want.status, want.count,
                       out_byte_o, last_o, status_o, bytes_sent_o);
          end
        end
      end
      if (rx_hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void queue_item(logic [2:0] act, logic [16:0] len, logic [7:0] b,
                                     logic ll);
    request_q.push_back('{action: act, length: len, data: b, line_last: ll});
  endfunction

  // Fields a request does not use are left random
  task automatic queue_chunk(int unsigned len, logic [7:0] first_byte = 8'h00,
                             logic fixed_first = 1'b0);
    queue_item(ACT_START, 17'(len), 8'($urandom), 1'($urandom));
    for (int unsigned i = 0; i < len; i++)
      queue_item(ACT_DATA, 17'($urandom), (i == 0 && fixed_first) ? first_byte : 8'($urandom),
                 1'($urandom));
  endtask

  task automatic queue_chunks(int unsigned n_items, int unsigned max_len);
    int unsigned made;
    int unsigned len;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, max_len);
      else len = $urandom_range(1, (max_len < 24) ? max_len : 24);
      queue_chunk(len);
      made += len + 1;
    end
  endtask

  task automatic queue_trailer_line(int unsigned n_name, int unsigned n_value);
    repeat (n_name) queue_item(ACT_NAME, 17'($urandom), 8'($urandom), 1'($urandom));
    for (int unsigned i = 1; i <= n_value; i++)
      queue_item(ACT_VALUE, 17'($urandom), 8'($urandom), i == n_value);
  endtask

  task automatic set_idle(int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_q.size() != 0 || in_valid_i || framed_stream_q.size() != 0);
  endtask

  // Write the limit only while nothing is in flight
  task automatic write_limit(logic [16:0] value);
    wait_idle();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    limit_reg = value;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned tail;
    int unsigned pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: shortest chunks, extreme bytes, a one-digit 'a' length
    queue_chunk(1, 8'h00, 1'b1);
    queue_chunk(2, 8'hff, 1'b1);
    queue_chunk(10);

    // Limit at one: only single-byte chunks get through
    write_limit(17'd1);
    set_idle(0, 59);
    repeat (5) queue_chunk(1);

    // Register above the build limit; the build limit caps it
    write_limit(LimitTop);
    set_idle(0, 0);
    queue_chunk(20);

    write_limit(LimitReset);
    set_idle(59, 0);
    queue_chunks(30, 40);
    wait_idle();
    set_idle(0, 59);
    queue_chunks(30, 40);
    wait_idle();
    set_idle(11, 11);
    queue_chunks(30, 40);
    wait_idle();
    set_idle(0, 0);
    queue_chunks(30, 40);
    wait_idle();

    // Hold the output for a long stretch while requests keep coming
    @(negedge clk_i);
    rx_hold_left = 300;
    queue_chunks(30, 24);
    wait_idle();

    write_limit(17'($urandom_range(16, 64)));
    set_idle(0, 59);
    queue_chunks(16, limit_reg);
    queue_chunk(limit_reg);
    wait_idle();

    set_idle(11, 11);
    tail = $urandom_range(0, 3);
    if (tail <= 1) begin
      queue_item(ACT_END, 17'($urandom), 8'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 5))
        queue_trailer_line($urandom_range(1, 4), $urandom_range(1, 4));
      queue_item(ACT_FINISH, 17'($urandom), 8'($urandom), 1'($urandom));
    end else if (tail == 2) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        // zero limit rejects any length
        write_limit('0);
        queue_item(ACT_START, 17'($urandom_range(1, MaxChunk)), 8'($urandom), 1'($urandom));
      end else if (pick == 1) begin
        queue_item(ACT_START, '0, 8'($urandom), 1'($urandom));
      end else begin
        queue_item(ACT_START, 17'($urandom_range(int'(limit_reg) + 1, int'(LimitTop))),
                   8'($urandom), 1'($urandom));
      end
    end else begin
      queue_item(ACT_END, 17'($urandom), 8'($urandom), 1'($urandom));
      queue_trailer_line($urandom_range(1, 3), $urandom_range(1, 3));
      pick = $urandom_range(0, 4);
      case (pick)
        0: queue_item(ACT_VALUE, 17'($urandom), 8'($urandom), 1'($urandom));
        1: queue_item(ACT_DATA, 17'($urandom), 8'($urandom), 1'($urandom));
        2: queue_item(ACT_START, 17'd1, 8'($urandom), 1'($urandom));
        3: queue_item($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B, 17'($urandom),
                      8'($urandom), 1'($urandom));
        default: begin
          // name byte once the value part has begun
          queue_item(ACT_NAME, 17'($urandom), 8'($urandom), 1'($urandom));
          queue_item(ACT_VALUE, 17'($urandom), 8'($urandom), 1'b0);
          queue_item(ACT_NAME, 17'($urandom), 8'($urandom), 1'($urandom));
        end
      endcase
    end
    // Anything after the error or the closing line is out of sequence
    repeat (24) queue_item(3'($urandom_range(0, 7)), 17'($urandom), 8'($urandom), 1'($urandom));

    wait_idle();
    set_idle(0, 0);
    repeat (20) @(posedge clk_i);
    if (byte_faults == 0 && framed_stream_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
